// File: rtl/lesc_pkg.sv
package lesc_pkg;

    localparam int OP_W      = 2;
    localparam int IDX_W     = 5;
    localparam int ROW_W     = 32;
    localparam int ELEM_W    = 5;
    localparam int POS_W     = 5;
    localparam int STATUS_W  = 2;
    localparam int OUT_CNT_W = 32;
    localparam int EC_W      = 6;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_ROW = 2'd0,
        OP_LOAD_EXT = 2'd1,
        OP_START    = 2'd2,
        OP_STEP     = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_NOT_STARTED = 2'd1,
        ST_RANGE       = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COPY,
        S_READ,
        S_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        t_status               status;
        logic                  swapped;
        logic [ELEM_W-1:0]     left_element;
        logic [ELEM_W-1:0]     right_element;
        logic [OUT_CNT_W-1:0]  sample_count;
    } t_result;

endpackage

// File: rtl/lesc_if.sv
interface lesc_in_if;
    logic                           valid;
    logic                           ready;
    logic [lesc_pkg::OP_W-1:0]      operation;
    logic [lesc_pkg::IDX_W-1:0]     index;
    logic [lesc_pkg::ROW_W-1:0]     row_bits;
    logic [lesc_pkg::ELEM_W-1:0]    element;
    logic                           do_update;
    logic [lesc_pkg::POS_W-1:0]     position;

    modport source (
        output valid, operation, index, row_bits, element, do_update, position,
        input  ready
    );
    modport sink (
        input  valid, operation, index, row_bits, element, do_update, position,
        output ready
    );
endinterface

interface lesc_out_if;
    logic                             valid;
    logic                             ready;
    logic [lesc_pkg::STATUS_W-1:0]    status;
    logic                             swapped;
    logic [lesc_pkg::ELEM_W-1:0]      left_element;
    logic [lesc_pkg::ELEM_W-1:0]      right_element;
    logic [lesc_pkg::OUT_CNT_W-1:0]   sample_count;

    modport source (
        output valid, status, swapped, left_element, right_element, sample_count,
        input  ready
    );
    modport sink (
        input  valid, status, swapped, left_element, right_element, sample_count,
        output ready
    );
endinterface

// File: rtl/linear_extension_swap_chain_unit.sv
// Swap chain over linear extensions of a partial order.
// i_in takes one word per item: load an order row, load an initial extension
// entry, start the chain, or step it with an outside coin and left position.
// o_out returns exactly one word per item, in order: status, swap flag, the
// pair now at position and position+1, and the saturating sample count.
// i_cfg_we/i_cfg_wdata write the element count; write it only while idle.
// One item is in work at a time; the next is taken the cycle after the word
// of the last one is loaded into o_out. Path from accept to the word in o_out:
//   loads and a step that needs no pair read go straight to the finishing state;
//   start copies n entries, one per cycle through the initial store read port;
//   a step reads the extension banks, then the order row that the fetched right
//   element addresses. n is the element count, capped at MAX_ELEMENTS.
// The extension is split into even and odd position banks so that a pair is
// read and written back in one access per bank.
// A word in o_out is held while o_out.ready is low; the next item is taken
// meanwhile and its word waits in the finishing state until the slot frees.
// Reset clears the chain state, count and element count; the stores need no
// clearing pass and hold nothing defined until loaded.
module linear_extension_swap_chain_unit #(
    parameter int MAX_ELEMENTS = 32,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lesc_pkg::EC_W-1:0]   i_cfg_wdata,
    lesc_in_if.sink                     i_in,
    lesc_out_if.source                  o_out
);

    localparam int AW  = $clog2(MAX_ELEMENTS);
    localparam int BD  = (MAX_ELEMENTS + 1) / 2;
    localparam int BAW = (BD > 1) ? $clog2(BD) : 1;
    localparam int NW  = $clog2(MAX_ELEMENTS + 1);

    lesc_pkg::t_state           r_state;
    lesc_pkg::t_state           n_state;
    logic                       r_started;
    logic [COUNT_WIDTH-1:0]     r_count;
    logic [lesc_pkg::EC_W-1:0]  r_ec;
    logic                       r_cpy_v;
    logic [NW-1:0]              r_cpy_idx;
    logic [NW-1:0]              r_cnt;
    logic                       r_try;
    logic                       r_pos_odd;
    logic [BAW-1:0]             r_bae;
    logic [BAW-1:0]             r_bao;
    logic [lesc_pkg::ELEM_W-1:0] r_e1;
    logic [lesc_pkg::ELEM_W-1:0] r_e2;
    lesc_pkg::t_result          r_res;

    lesc_pkg::t_op              w_op;
    logic [NW-1:0]              w_n;
    logic                       w_acc;
    logic                       w_acc_start;
    logic                       w_acc_step;
    logic                       w_inr;
    logic                       w_n2;
    logic                       w_bad;
    logic                       w_idx_ok;
    lesc_pkg::t_status          w_status;
    logic [BAW-1:0]             w_bae;
    logic [BAW-1:0]             w_bao;
    logic [lesc_pkg::ELEM_W-1:0] w_left;
    logic [lesc_pkg::ELEM_W-1:0] w_right;
    logic                       w_gt;
    logic                       w_swap;
    logic                       w_out_free;
    logic                       w_out_load;
    lesc_pkg::t_result          w_word;

    logic                       w_ord_we;
    logic [AW-1:0]              w_ord_raddr;
    logic [lesc_pkg::ROW_W-1:0] w_ord_rdata;
    logic                       w_ini_we;
    logic [AW-1:0]              w_ini_raddr;
    logic [lesc_pkg::ELEM_W-1:0] w_ini_rdata;
    logic                       w_be_we;
    logic [BAW-1:0]             w_be_waddr;
    logic [lesc_pkg::ELEM_W-1:0] w_be_wdata;
    logic [lesc_pkg::ELEM_W-1:0] w_be_rdata;
    logic                       w_bo_we;
    logic [BAW-1:0]             w_bo_waddr;
    logic [lesc_pkg::ELEM_W-1:0] w_bo_wdata;
    logic [lesc_pkg::ELEM_W-1:0] w_bo_rdata;

    assign w_op        = lesc_pkg::t_op'(i_in.operation);
    assign i_in.ready  = (r_state == lesc_pkg::S_IDLE);
    assign w_acc       = i_in.valid && i_in.ready;
    assign w_acc_start = w_acc && (w_op == lesc_pkg::OP_START);
    assign w_acc_step  = w_acc && (w_op == lesc_pkg::OP_STEP);

    always_comb begin
        if (32'(r_ec) > 32'(MAX_ELEMENTS)) begin
            w_n = NW'(MAX_ELEMENTS);
        end else begin
            w_n = NW'(r_ec);
        end
    end

    assign w_inr    = (32'(i_in.position) + 32'd1) < 32'(w_n);
    assign w_n2     = 32'(w_n) >= 32'd2;
    assign w_bad    = i_in.do_update && w_n2 && !w_inr;
    assign w_idx_ok = 32'(i_in.index) < 32'(MAX_ELEMENTS);

    always_comb begin
        w_status = lesc_pkg::ST_OK;
        if (w_op == lesc_pkg::OP_STEP) begin
            if (!r_started) begin
                w_status = lesc_pkg::ST_NOT_STARTED;
            end else if (w_bad) begin
                w_status = lesc_pkg::ST_RANGE;
            end
        end
    end

    always_comb begin
        logic [31:0] half;
        half  = 32'(i_in.position) >> 1;
        w_bao = BAW'(half);
        if (i_in.position[0]) begin
            w_bae = BAW'(half + 32'd1);
        end else begin
            w_bae = BAW'(half);
        end
    end

    assign w_left  = r_pos_odd ? w_bo_rdata : w_be_rdata;
    assign w_right = r_pos_odd ? w_be_rdata : w_bo_rdata;

    assign w_gt   = (32'(r_e1) < 32'(MAX_ELEMENTS)) && (32'(r_e2) < 32'(MAX_ELEMENTS))
                    && w_ord_rdata[r_e1];
    assign w_swap = r_try && !w_gt;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lesc_pkg::S_IDLE: begin
                if (w_acc) begin
                    unique case (w_op)
                        lesc_pkg::OP_LOAD_ROW,
                        lesc_pkg::OP_LOAD_EXT: n_state = lesc_pkg::S_DONE;
                        lesc_pkg::OP_START: begin
                            n_state = (w_n == '0) ? lesc_pkg::S_DONE : lesc_pkg::S_COPY;
                        end
                        lesc_pkg::OP_STEP: begin
                            if (r_started && !w_bad && w_inr) begin
                                n_state = lesc_pkg::S_READ;
                            end else begin
                                n_state = lesc_pkg::S_DONE;
                            end
                        end
                        default: n_state = lesc_pkg::S_DONE;
                    endcase
                end
            end
            lesc_pkg::S_COPY: begin
                if ((32'(r_cnt) + 32'd1) == 32'(w_n)) begin
                    n_state = lesc_pkg::S_DONE;
                end
            end
            lesc_pkg::S_READ: n_state = lesc_pkg::S_CMP;
            lesc_pkg::S_CMP:  n_state = lesc_pkg::S_DONE;
            lesc_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = lesc_pkg::S_IDLE;
                end
            end
            default: n_state = lesc_pkg::S_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        w_ord_we    = w_acc && (w_op == lesc_pkg::OP_LOAD_ROW) && w_idx_ok;
        w_ini_we    = w_acc && (w_op == lesc_pkg::OP_LOAD_EXT) && w_idx_ok;
        w_ini_raddr = AW'(r_cnt);
        w_ord_raddr = AW'(w_right);
        w_be_we     = 1'b0;
        w_bo_we     = 1'b0;
        w_be_waddr  = r_bae;
        w_bo_waddr  = r_bao;
        w_be_wdata  = r_pos_odd ? r_e1 : r_e2;
        w_bo_wdata  = r_pos_odd ? r_e2 : r_e1;
        w_out_load  = 1'b0;
        unique case (r_state)
            lesc_pkg::S_CMP: begin
                w_be_we = w_swap;
                w_bo_we = w_swap;
            end
            lesc_pkg::S_DONE: w_out_load = w_out_free;
            default: ;
        endcase
        if (r_cpy_v) begin
            w_be_we    = !r_cpy_idx[0];
            w_bo_we    = r_cpy_idx[0];
            w_be_waddr = BAW'(r_cpy_idx >> 1);
            w_bo_waddr = BAW'(r_cpy_idx >> 1);
            w_be_wdata = w_ini_rdata;
            w_bo_wdata = w_ini_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lesc_pkg::S_IDLE;
            r_started <= 1'b0;
            r_count   <= '0;
            r_ec      <= '0;
            r_cpy_v   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cpy_v <= (r_state == lesc_pkg::S_COPY);
            if (i_cfg_we) begin
                r_ec <= i_cfg_wdata;
            end
            if (w_acc_start) begin
                r_started <= 1'b1;
                r_count   <= COUNT_WIDTH'(1);
            end else if (w_acc_step && r_started && !w_bad && (r_count != '1)) begin
                r_count <= r_count + COUNT_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_res     <= '{status: w_status, swapped: 1'b0, left_element: '0,
                           right_element: '0, sample_count: '0};
            r_try     <= i_in.do_update;
            r_pos_odd <= i_in.position[0];
            r_bae     <= w_bae;
            r_bao     <= w_bao;
            r_cnt     <= '0;
        end
        if (r_state == lesc_pkg::S_COPY) begin
            r_cnt     <= r_cnt + NW'(1);
            r_cpy_idx <= r_cnt;
        end
        if (r_state == lesc_pkg::S_READ) begin
            r_e1 <= w_left;
            r_e2 <= w_right;
        end
        if (r_state == lesc_pkg::S_CMP) begin
            r_res <= '{status: r_res.status, swapped: w_swap,
                       left_element: w_swap ? r_e2 : r_e1,
                       right_element: w_swap ? r_e1 : r_e2,
                       sample_count: r_res.sample_count};
        end
    end

    always_comb begin
        w_word              = r_res;
        w_word.sample_count = lesc_pkg::OUT_CNT_W'(r_count);
    end

    lesc_ram #(.WIDTH(lesc_pkg::ROW_W), .DEPTH(MAX_ELEMENTS)) u_order (
        .i_clk   (i_clk),
        .i_we    (w_ord_we),
        .i_waddr (AW'(i_in.index)),
        .i_wdata (i_in.row_bits),
        .i_raddr (w_ord_raddr),
        .o_rdata (w_ord_rdata)
    );

    lesc_ram #(.WIDTH(lesc_pkg::ELEM_W), .DEPTH(MAX_ELEMENTS)) u_init (
        .i_clk   (i_clk),
        .i_we    (w_ini_we),
        .i_waddr (AW'(i_in.index)),
        .i_wdata (i_in.element),
        .i_raddr (w_ini_raddr),
        .o_rdata (w_ini_rdata)
    );

    lesc_ram #(.WIDTH(lesc_pkg::ELEM_W), .DEPTH(BD)) u_bank_even (
        .i_clk   (i_clk),
        .i_we    (w_be_we),
        .i_waddr (w_be_waddr),
        .i_wdata (w_be_wdata),
        .i_raddr (w_bae),
        .o_rdata (w_be_rdata)
    );

    lesc_ram #(.WIDTH(lesc_pkg::ELEM_W), .DEPTH(BD)) u_bank_odd (
        .i_clk   (i_clk),
        .i_we    (w_bo_we),
        .i_waddr (w_bo_waddr),
        .i_wdata (w_bo_wdata),
        .i_raddr (w_bao),
        .o_rdata (w_bo_rdata)
    );

    lesc_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_out_load),
        .i_word  (w_word),
        .o_free  (w_out_free),
        .o_out   (o_out)
    );

    a_cmp_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lesc_pkg::S_CMP |-> $past(r_state) == lesc_pkg::S_READ)
        else $error("compare without pair read");

    a_copy_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cpy_v |-> 32'(r_cpy_idx) < 32'(w_n))
        else $error("copy beyond element count");

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_started |-> r_count == '0)
        else $error("count moved before start");

    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started && $past(r_started) && !$past(w_acc_start) |-> r_count >= $past(r_count))
        else $error("count went backwards");

endmodule

// File: rtl/lesc_ram.sv
module lesc_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/lesc_out_stage.sv
module lesc_out_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  lesc_pkg::t_result     i_word,
    output logic                  o_free,
    lesc_out_if.source            o_out
);

    logic               r_valid;
    lesc_pkg::t_result  r_word;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.status        = r_word.status;
    assign o_out.swapped       = r_word.swapped;
    assign o_out.left_element  = r_word.left_element;
    assign o_out.right_element = r_word.right_element;
    assign o_out.sample_count  = r_word.sample_count;

endmodule

// File: verif/tb_linear_extension_swap_chain_unit.sv
`timescale 1ns / 1ps

module tb_linear_extension_swap_chain_unit;

    localparam int MAX_ELEMENTS  = 32;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        lesc_pkg::t_op                  op;
        logic [lesc_pkg::IDX_W-1:0]     index;
        logic [lesc_pkg::ROW_W-1:0]     row_bits;
        logic [lesc_pkg::ELEM_W-1:0]    element;
        logic                           do_update;
        logic [lesc_pkg::POS_W-1:0]     position;
    } t_chain_word;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [lesc_pkg::EC_W-1:0]     cfg_wdata;

    int send_idle_pct;
    int recv_idle_pct;
    int gen_count;
    int mismatches;
    int stall_cycles;
    bit moved;

    t_chain_word        pending_words[$];
    lesc_pkg::t_result  expected_results[$];

    logic [lesc_pkg::ROW_W-1:0]      order_rows[MAX_ELEMENTS];
    logic [lesc_pkg::ELEM_W-1:0]     initial_ext[MAX_ELEMENTS];
    logic [lesc_pkg::ELEM_W-1:0]     chain_perm[MAX_ELEMENTS];
    logic                            chain_armed;
    logic [lesc_pkg::OUT_CNT_W-1:0]  sample_total;
    logic [lesc_pkg::EC_W-1:0]       elem_count;

    t_chain_word        drv_word;
    t_chain_word        seen_word;
    lesc_pkg::t_result  seen_result;
    lesc_pkg::t_result  want;

    lesc_in_if  in_if();
    lesc_out_if out_if();

    linear_extension_swap_chain_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic lesc_pkg::t_result predict_chain_step(t_chain_word w);
        lesc_pkg::t_result             r;
        int                            n;
        logic                          in_range;
        logic [lesc_pkg::ELEM_W-1:0]   e1;
        logic [lesc_pkg::ELEM_W-1:0]   e2;
        r.status        = lesc_pkg::ST_OK;
        r.swapped       = 1'b0;
        r.left_element  = '0;
        r.right_element = '0;
        n        = (elem_count > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(elem_count);
        in_range = (int'(w.position) + 1 < n);
        case (w.op)
            lesc_pkg::OP_LOAD_ROW: order_rows[w.index] = w.row_bits;
            lesc_pkg::OP_LOAD_EXT: initial_ext[w.index] = w.element;
            lesc_pkg::OP_START: begin
                for (int i = 0; i < n; i++)
                    chain_perm[i] = initial_ext[i];
                chain_armed  = 1'b1;
                sample_total = 1;
            end
            default: begin
                if (!chain_armed) begin
                    r.status = lesc_pkg::ST_NOT_STARTED;
                end else if (w.do_update && n >= 2 && !in_range) begin
                    r.status = lesc_pkg::ST_RANGE;
                end else begin
                    if (sample_total != '1)
                        sample_total++;
                    if (w.do_update && n >= 2) begin
                        e1 = chain_perm[w.position];
                        e2 = chain_perm[w.position + 1];
                        // swap unless the right element sits above the left
                        if (!order_rows[e2][e1]) begin
                            chain_perm[w.position]     = e2;
                            chain_perm[w.position + 1] = e1;
                            r.swapped = 1'b1;
                        end
                    end
                    if (in_range) begin
                        r.left_element  = chain_perm[w.position];
                        r.right_element = chain_perm[w.position + 1];
                    end
                end
            end
        endcase
        r.sample_count = sample_total;
        return r;
    endfunction

    function automatic logic [lesc_pkg::ROW_W-1:0] random_row_bits();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_word(lesc_pkg::t_op op, int idx, logic [lesc_pkg::ROW_W-1:0] bits,
                             int elem, bit coin, int pos);
        t_chain_word w;
        w.op        = op;
        w.index     = idx[lesc_pkg::IDX_W-1:0];
        w.row_bits  = bits;
        w.element   = elem[lesc_pkg::ELEM_W-1:0];
        w.do_update = coin;
        w.position  = pos[lesc_pkg::POS_W-1:0];
        pending_words.push_back(w);
    endtask

    task automatic step(bit coin, int pos);
        push_word(lesc_pkg::OP_STEP, 0, '0, 0, coin, pos);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || in_if.valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_element_count(int v);
        wait_idle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v[lesc_pkg::EC_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
        gen_count = (v > MAX_ELEMENTS) ? MAX_ELEMENTS : v;
    endtask

    task automatic run_random_phase(int count_cfg, int items, int drain_at);
        int r;
        int pos;
        write_element_count(count_cfg);
        push_word(lesc_pkg::OP_START, 0, '0, 0, 1'b0, 0);
        for (int k = 0; k < items; k++) begin
            // hold the sender until the block has drained
            if (k == drain_at)
                wait_idle();
            r = $urandom_range(0, 99);
            if (r < 8) begin
                push_word(lesc_pkg::OP_LOAD_ROW, $urandom_range(0, 31), random_row_bits(), 0,
                          1'b0, 0);
            end else if (r < 16) begin
                push_word(lesc_pkg::OP_LOAD_EXT, $urandom_range(0, 31), '0,
                          $urandom_range(0, 31), 1'b0, 0);
            end else if (r < 20) begin
                push_word(lesc_pkg::OP_START, 0, '0, 0, 1'b0, 0);
            end else begin
                if (gen_count >= 2 && $urandom_range(0, 99) < 85)
                    pos = $urandom_range(0, gen_count - 2);
                else
                    pos = $urandom_range(0, 30);
                step($urandom_range(0, 99) < 75, pos);
            end
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                drv_word = pending_words.pop_front();
                in_if.valid     <= 1'b1;
                in_if.operation <= drv_word.op;
                in_if.index     <= drv_word.index;
                in_if.row_bits  <= drv_word.row_bits;
                in_if.element   <= drv_word.element;
                in_if.do_update <= drv_word.do_update;
                in_if.position  <= drv_word.position;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n)
            out_if.ready <= 1'b0;
        else
            out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            chain_armed  = 1'b0;
            sample_total = '0;
            elem_count   = '0;
            stall_cycles = 0;
        end else begin
            moved = 1'b0;
            if (cfg_we)
                elem_count = cfg_wdata;
            if (in_if.valid && in_if.ready) begin
                seen_word.op        = lesc_pkg::t_op'(in_if.operation);
                seen_word.index     = in_if.index;
                seen_word.row_bits  = in_if.row_bits;
                seen_word.element   = in_if.element;
                seen_word.do_update = in_if.do_update;
                seen_word.position  = in_if.position;
                expected_results.push_back(predict_chain_step(seen_word));
                moved = 1'b1;
            end
            if (out_if.valid && out_if.ready) begin
                moved = 1'b1;
                seen_result.status        = lesc_pkg::t_status'(out_if.status);
                seen_result.swapped       = out_if.swapped;
                seen_result.left_element  = out_if.left_element;
                seen_result.right_element = out_if.right_element;
                seen_result.sample_count  = out_if.sample_count;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected word: st %0d sw %0d pair %0d,%0d cnt %0d",
                                 $realtime, seen_result.status, seen_result.swapped,
                                 seen_result.left_element, seen_result.right_element,
                                 seen_result.sample_count);
                end else begin
                    want = expected_results.pop_front();
                    if (seen_result.status !== want.status ||
                        seen_result.swapped !== want.swapped ||
                        seen_result.left_element !== want.left_element ||
                        seen_result.right_element !== want.right_element ||
                        seen_result.sample_count !== want.sample_count) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: exp %0d %0d %0d,%0d %0d got %0d %0d %0d,%0d %0d",
                                     $realtime, want.status, want.swapped, want.left_element,
                                     want.right_element, want.sample_count,
                                     seen_result.status, seen_result.swapped,
                                     seen_result.left_element, seen_result.right_element,
                                     seen_result.sample_count);
                    end
                end
            end
            if (!moved && (pending_words.size() != 0 || in_if.valid ||
                           expected_results.size() != 0))
                stall_cycles++;
            else
                stall_cycles = 0;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        in_if.valid     = 1'b0;
        in_if.operation = lesc_pkg::OP_LOAD_ROW;
        in_if.index     = '0;
        in_if.row_bits  = '0;
        in_if.element   = '0;
        in_if.do_update = 1'b0;
        in_if.position  = '0;
        out_if.ready    = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        rst_n           = 1'b0;
        mismatches      = 0;
        gen_count       = 0;
        send_idle_pct   = 24;
        recv_idle_pct   = 85;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        step(1'b1, 0);
        step(1'b0, 30);
        push_word(lesc_pkg::OP_LOAD_ROW, 0, '0, 0, 1'b0, 0);
        push_word(lesc_pkg::OP_LOAD_ROW, 31, '1, 0, 1'b0, 0);
        push_word(lesc_pkg::OP_LOAD_EXT, 31, '0, 31, 1'b0, 0);
        push_word(lesc_pkg::OP_START, 0, '0, 0, 1'b0, 0);
        step(1'b1, 0);

        write_element_count(2);
        push_word(lesc_pkg::OP_LOAD_ROW, 1, 32'h1, 0, 1'b0, 0);
        push_word(lesc_pkg::OP_LOAD_ROW, 2, 32'h3, 0, 1'b0, 0);
        push_word(lesc_pkg::OP_LOAD_EXT, 0, '0, 0, 1'b0, 0);
        push_word(lesc_pkg::OP_LOAD_EXT, 1, '0, 1, 1'b0, 0);
        push_word(lesc_pkg::OP_START, 0, '0, 0, 1'b0, 0);
        step(1'b1, 0);
        step(1'b1, 1);
        step(1'b0, 1);
        push_word(lesc_pkg::OP_LOAD_EXT, 0, '0, 1, 1'b0, 0);
        step(1'b0, 0);

        write_element_count(3);
        push_word(lesc_pkg::OP_LOAD_EXT, 0, '0, 0, 1'b0, 0);
        push_word(lesc_pkg::OP_LOAD_EXT, 1, '0, 31, 1'b0, 0);
        push_word(lesc_pkg::OP_LOAD_EXT, 2, '0, 1, 1'b0, 0);
        push_word(lesc_pkg::OP_START, 0, '0, 0, 1'b0, 0);
        step(1'b1, 0);
        step(1'b1, 1);
        step(1'b1, 1);
        push_word(lesc_pkg::OP_START, 0, '0, 0, 1'b0, 0);
        step(1'b0, 0);

        // fill every order row and extension entry so no read sees an unwritten entry
        for (int i = 0; i < MAX_ELEMENTS; i++)
            push_word(lesc_pkg::OP_LOAD_ROW, i, random_row_bits(), 0, 1'b0, 0);
        for (int i = 0; i < MAX_ELEMENTS; i++)
            push_word(lesc_pkg::OP_LOAD_EXT, i, '0, $urandom_range(0, 31), 1'b0, 0);

        run_random_phase(32, 50, -1);
        run_random_phase(63, 40, -1);
        run_random_phase(7, 45, 25);
        send_idle_pct = 85;
        recv_idle_pct = 24;
        run_random_phase(2, 30, -1);
        run_random_phase(1, 20, -1);
        run_random_phase(0, 20, -1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(20, 45, -1);
        run_random_phase(32, 55, -1);

        wait_idle();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: linear_extension_swap_chain_unit.f
rtl/lesc_pkg.sv
rtl/lesc_if.sv
rtl/lesc_ram.sv
rtl/lesc_out_stage.sv
rtl/linear_extension_swap_chain_unit.sv
verif/tb_linear_extension_swap_chain_unit.sv
